// ----- rtl/pkrpa_pkg.sv -----
// ----------------------------------------------------------------------------
// pkrpa_pkg: shared constants and types
// Sizes, request and status codes, and the command and status structs that
// join the controller and the datapath of the reward/probability table.
// ----------------------------------------------------------------------------
package pkrpa_pkg;

  // Table sizes.
  localparam int NUM_STATES  = 64;
  localparam int MAX_ENTRIES = 16;
  localparam int DEPTH       = NUM_STATES * MAX_ENTRIES;

  // Derived widths.
  localparam int SID_W  = $clog2(NUM_STATES);
  localparam int IDX_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  // Field widths of the stream words.
  localparam int REQ_W    = 2;
  localparam int STATE_W  = 6;
  localparam int DATA_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = REQ_W;
  localparam int OUT_TDATA_W = 40;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SLOT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // capture the input word and read the count
    logic load;    // set up the walk over the list
    logic scan;    // search the list for the reward
    logic shift;   // move later entries down by one
    logic finish;  // commit the writes and load the result word
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_walk;    // insert or query: a search is needed
    logic is_delete;  // delete request
    logic slot_bad;   // delete slot at or beyond the count
    logic walk_done;  // search or shift has finished
    logic out_free;   // result register can take a word
  } dp_status_t;

endpackage

// ----- rtl/pkrpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// pkrpa_ctrl: request sequencer
// Steps one request through count read, list walk and commit, and gives the
// datapath at most one command per cycle.
// ----------------------------------------------------------------------------
module pkrpa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  pkrpa_pkg::dp_status_t status,
  output pkrpa_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands. No word is taken while reset is held.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = !rst;
        if (s_axis_tvalid && !rst) begin
          cmd.accept = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        if (status.is_walk) begin
          state_next = S_SCAN;
        end else if (status.is_delete && !status.slot_bad) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.walk_done) begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (status.walk_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/pkrpa_datapath.sv -----
// ----------------------------------------------------------------------------
// pkrpa_datapath: table storage and request arithmetic
// Holds the per-state counts and the entry memories, walks a list one entry
// per cycle, applies the insert, delete or query and drives the result word.
// ----------------------------------------------------------------------------
module pkrpa_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [pkrpa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic [pkrpa_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [pkrpa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  pkrpa_pkg::ctrl_cmd_t                 cmd,
  output pkrpa_pkg::dp_status_t                status
);

  // Input word fields.
  logic [pkrpa_pkg::STATE_W-1:0] in_state;
  logic [pkrpa_pkg::DATA_W-1:0]  in_reward;
  logic [pkrpa_pkg::DATA_W-1:0]  in_prob;
  logic [pkrpa_pkg::SLOT_W-1:0]  in_slot;
  logic [pkrpa_pkg::SID_W-1:0]   in_sid;

  assign in_state  = s_axis_tdata[5:0];
  assign in_reward = s_axis_tdata[37:6];
  assign in_prob   = s_axis_tdata[69:38];
  assign in_slot   = s_axis_tdata[73:70];
  assign in_sid    = pkrpa_pkg::SID_W'(32'(in_state) % pkrpa_pkg::NUM_STATES);

  // Request registers.
  logic [pkrpa_pkg::REQ_W-1:0]   req_q;
  logic [pkrpa_pkg::DATA_W-1:0]  key_q;
  logic [pkrpa_pkg::DATA_W-1:0]  pin_q;
  logic [pkrpa_pkg::SLOT_W-1:0]  slot_q;
  logic [pkrpa_pkg::SID_W-1:0]   sid_q;
  logic [pkrpa_pkg::ADDR_W-1:0]  base_q;

  // Count store with one valid bit per state.
  logic [pkrpa_pkg::IDX_W-1:0]      cnt_mem [pkrpa_pkg::NUM_STATES];
  logic [pkrpa_pkg::NUM_STATES-1:0] cnt_valid;
  logic [pkrpa_pkg::IDX_W-1:0]      cnt_rd;
  logic                             cnt_vld_rd;
  logic [pkrpa_pkg::IDX_W-1:0]      cnt_eff;
  logic [pkrpa_pkg::IDX_W-1:0]      cnt_new;

  // Entry memories and their ports.
  logic [pkrpa_pkg::DATA_W-1:0] rew_mem  [pkrpa_pkg::DEPTH];
  logic [pkrpa_pkg::DATA_W-1:0] prob_mem [pkrpa_pkg::DEPTH];
  logic [pkrpa_pkg::DATA_W-1:0] rew_rd;
  logic [pkrpa_pkg::DATA_W-1:0] prob_rd;
  logic [pkrpa_pkg::ADDR_W-1:0] rd_addr;
  logic                         wr_en;
  logic [pkrpa_pkg::ADDR_W-1:0] wr_addr;
  logic [pkrpa_pkg::DATA_W-1:0] wr_rew;
  logic [pkrpa_pkg::DATA_W-1:0] wr_prob;

  // Walk state.
  logic [pkrpa_pkg::IDX_W-1:0]  ridx;
  logic [pkrpa_pkg::IDX_W-1:0]  pidx;
  logic                         pend;
  logic                         issue;
  logic                         match;
  logic                         hit;
  logic [pkrpa_pkg::IDX_W-1:0]  hit_idx;
  logic [pkrpa_pkg::DATA_W-1:0] hit_prob;

  // Result computation.
  logic                           is_insert;
  logic                           is_query;
  logic                           is_delete;
  logic                           slot_bad;
  logic                           full;
  logic [pkrpa_pkg::DATA_W:0]     sum;
  logic [pkrpa_pkg::DATA_W-1:0]   sum_sat;
  logic [pkrpa_pkg::DATA_W-1:0]   res_prob;
  logic                           res_found;
  logic [pkrpa_pkg::STATUS_W-1:0] res_status;

  logic                           m_valid;
  logic [pkrpa_pkg::OUT_TDATA_W-1:0] m_data;

  assign is_insert = (req_q == pkrpa_pkg::REQ_INSERT);
  assign is_delete = (req_q == pkrpa_pkg::REQ_DELETE);
  assign is_query  = (req_q == pkrpa_pkg::REQ_QUERY);

  // The count read at accept stays put for the whole request.
  assign cnt_eff  = cnt_vld_rd ? cnt_rd : '0;
  assign slot_bad = (32'(slot_q) >= 32'(cnt_eff));
  assign full     = (32'(cnt_eff) >= pkrpa_pkg::MAX_ENTRIES);

  // Capture the request and read its count.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q      <= s_axis_tuser;
      key_q      <= in_reward;
      pin_q      <= in_prob;
      slot_q     <= in_slot;
      sid_q      <= in_sid;
      base_q     <= pkrpa_pkg::ADDR_W'(in_sid) * pkrpa_pkg::ADDR_W'(pkrpa_pkg::MAX_ENTRIES);
      cnt_rd     <= cnt_mem[in_sid];
      cnt_vld_rd <= cnt_valid[in_sid];
    end
  end

  // Count write-back at commit.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      cnt_mem[sid_q] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
    end else if (cmd.finish) begin
      cnt_valid[sid_q] <= 1'b1;
    end
  end

  // One read per cycle while walking: search from slot zero, shift from the
  // entry after the removed slot.
  assign match   = cmd.scan && pend && !hit && (rew_rd == key_q);
  assign issue   = (cmd.scan || cmd.shift) && (ridx < cnt_eff) && !hit && !match;
  assign rd_addr = base_q + pkrpa_pkg::ADDR_W'(ridx);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      hit  <= 1'b0;
    end else if (cmd.load) begin
      pend <= 1'b0;
      hit  <= 1'b0;
    end else begin
      pend <= issue;
      if (match) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ridx <= is_delete ? pkrpa_pkg::IDX_W'(32'(slot_q) + 1) : '0;
    end else if (issue) begin
      ridx <= pkrpa_pkg::IDX_W'(ridx + 1'b1);
    end
    pidx <= ridx;
    if (match) begin
      hit_idx  <= pidx;
      hit_prob <= prob_rd;
    end
  end

  // Memory read port with registered data.
  always_ff @(posedge clk) begin
    if (issue) begin
      rew_rd  <= rew_mem[rd_addr];
      prob_rd <= prob_mem[rd_addr];
    end
  end

  // Saturating accumulate of the probability.
  assign sum     = {1'b0, hit_prob} + {1'b0, pin_q};
  assign sum_sat = sum[pkrpa_pkg::DATA_W] ? '1 : sum[pkrpa_pkg::DATA_W-1:0];

  // Memory write port: shift moves an entry down, commit accumulates or
  // appends.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = base_q + pkrpa_pkg::ADDR_W'(cnt_eff);
    wr_rew  = key_q;
    wr_prob = pin_q;
    if (cmd.shift && pend) begin
      wr_en   = 1'b1;
      wr_addr = base_q + pkrpa_pkg::ADDR_W'(pidx) - pkrpa_pkg::ADDR_W'(1);
      wr_rew  = rew_rd;
      wr_prob = prob_rd;
    end else if (cmd.finish && is_insert && hit) begin
      wr_en   = 1'b1;
      wr_addr = base_q + pkrpa_pkg::ADDR_W'(hit_idx);
      wr_prob = sum_sat;
    end else if (cmd.finish && is_insert && !full) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rew_mem[wr_addr]  <= wr_rew;
      prob_mem[wr_addr] <= wr_prob;
    end
  end

  // Result fields and new count.
  always_comb begin
    res_prob   = '0;
    res_found  = 1'b0;
    res_status = pkrpa_pkg::ST_OK;
    cnt_new    = cnt_eff;
    case (req_q)
      pkrpa_pkg::REQ_INSERT: begin
        if (hit) begin
          res_found = 1'b1;
          if (sum[pkrpa_pkg::DATA_W]) begin
            res_status = pkrpa_pkg::ST_SAT;
          end
        end else if (full) begin
          res_status = pkrpa_pkg::ST_FULL;
        end else begin
          cnt_new = pkrpa_pkg::IDX_W'(cnt_eff + 1'b1);
        end
      end
      pkrpa_pkg::REQ_DELETE: begin
        if (slot_bad) begin
          res_status = pkrpa_pkg::ST_SLOT;
        end else begin
          cnt_new = pkrpa_pkg::IDX_W'(cnt_eff - 1'b1);
        end
      end
      pkrpa_pkg::REQ_QUERY: begin
        res_found = hit;
        res_prob  = hit ? hit_prob : '0;
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.finish) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_data <= {res_status, pkrpa_pkg::CNT_W'(cnt_new), res_found, res_prob};
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;

  // Status to the controller.
  assign status.is_walk   = is_insert || is_query;
  assign status.is_delete = is_delete;
  assign status.slot_bad  = slot_bad;
  assign status.walk_done = hit || (!pend && (ridx >= cnt_eff));
  assign status.out_free  = !m_valid || m_axis_tready;

endmodule

// ----- rtl/per_key_reward_prob_accumulator.sv -----
// ----------------------------------------------------------------------------
// per_key_reward_prob_accumulator: per-state reward/probability table
// Keeps a short list of (reward, probability) pairs for each state id and
// serves insert-or-accumulate, delete-slot and query requests.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel, one word per request, and each gives
// exactly one result word on the m_axis channel. The request code travels in
// s_axis_tuser; the other fields are packed in s_axis_tdata.
// Requests are handled one at a time. Each request steps through accept and
// count read, set-up, a walk over the list and commit. The result is valid in
// the cycle after the commit, when the next word can also be taken. The walk
// reads one entry per cycle from the entry memory's single read port: insert
// and query search from slot zero until a match or the end of the list; delete
// moves each entry above the slot down by one. A rejected delete or an unused
// code skips the walk and goes from set-up straight to commit.
// s_axis_tready is high only while no request is in flight and reset is low.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, the commit waits until that register is free.
// Reset clears every list count at once; the entry memories need no clearing.
// ----------------------------------------------------------------------------
module per_key_reward_prob_accumulator (
  input  logic                              clk,
  input  logic                              rst,
  // fields from bit 0: state_id[5:0], reward[37:6], prob[69:38],
  // slot_index[73:70], zero pad[79:74]
  input  logic [pkrpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // fields from bit 0: req_type[1:0]
  input  logic [pkrpa_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // fields from bit 0: prob_out[31:0], found[32], entry_count[37:33],
  // status[39:38]
  output logic [pkrpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);

  pkrpa_pkg::ctrl_cmd_t  cmd;
  pkrpa_pkg::dp_status_t status;

  // Request sequencer.
  pkrpa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  // Storage and arithmetic.
  pkrpa_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .status        (status)
  );

  // A result word only appears after a commit.
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.finish))
    else $error("result word appeared without a commit");

  // Only one request is in flight at a time.
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // The sequencer issues at most one command per cycle.
  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.load, cmd.scan, cmd.shift, cmd.finish}))
    else $error("more than one command at once");

  // A commit never happens while the output register holds a stalled word.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !cmd.finish)
    else $error("result word overwritten while stalled");

endmodule

// ----- tb/per_key_reward_prob_accumulator_tb.sv -----
// ----------------------------------------------------------------------------
// per_key_reward_prob_accumulator_tb: self-checking bench for the table
// Sends insert, delete, query and unused request words to the block, and
// predicts each result word from a private copy of the per-state lists.
// Every result word is compared field by field with the oldest prediction.
// A short directed run comes first. A long random run follows. It works mostly
// on four busy states so that lists fill, sums saturate and deletes shift.
// ----------------------------------------------------------------------------
module per_key_reward_prob_accumulator_tb;

  import pkrpa_pkg::*;

  // The request code that the block treats as a no-op.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_REQUESTS = 1400;
  localparam int IDLE_LIMIT      = 4000;
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_CYCLES    = 40;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [STATE_W-1:0] sid;
    logic [DATA_W-1:0]  reward;
    logic [DATA_W-1:0]  prob;
    logic [SLOT_W-1:0]  slot;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0]   prob_out;
    logic                found;
    logic [CNT_W-1:0]    count;
    logic [STATUS_W-1:0] status;
  } outcome_t;

  // Scoreboard: mirrors the per-state lists and keeps the predicted outcomes.
  class reward_table_sb;
    int                list_len [NUM_STATES];
    logic [DATA_W-1:0] key_mem  [NUM_STATES][MAX_ENTRIES];
    logic [DATA_W-1:0] prob_mem [NUM_STATES][MAX_ENTRIES];
    outcome_t          expected_outcomes [$];
    int                errors;

    function new();
      foreach (list_len[i]) list_len[i] = 0;
      errors = 0;
    endfunction

    function int find_key(int sid, int len, logic [DATA_W-1:0] k);
      for (int i = 0; i < len; i++) begin
        if (key_mem[sid][i] == k) return i;
      end
      return -1;
    endfunction

    // Apply one accepted request to the lists and queue its outcome.
    function void log_request(request_t r);
      outcome_t          e;
      int                sid;
      int                len;
      int                hit;
      logic [DATA_W:0]   total;
      sid = r.sid;
      len = list_len[sid];
      e = '0;
      e.status = ST_OK;
      case (r.kind)
        REQ_INSERT: begin
          hit = find_key(sid, len, r.reward);
          if (hit >= 0) begin
            total = {1'b0, prob_mem[sid][hit]} + {1'b0, r.prob};
            e.found = 1'b1;
            if (total[DATA_W]) begin
              total  = {1'b0, {DATA_W{1'b1}}};
              e.status = ST_SAT;
            end
            prob_mem[sid][hit] = total[DATA_W-1:0];
          end else if (len >= MAX_ENTRIES) begin
            e.status = ST_FULL;
          end else begin
            key_mem[sid][len]  = r.reward;
            prob_mem[sid][len] = r.prob;
            len++;
          end
        end
        REQ_DELETE: begin
          if (int'(r.slot) >= len) begin
            e.status = ST_SLOT;
          end else begin
            for (int i = int'(r.slot); i < len - 1; i++) begin
              key_mem[sid][i]  = key_mem[sid][i+1];
              prob_mem[sid][i] = prob_mem[sid][i+1];
            end
            len--;
          end
        end
        REQ_QUERY: begin
          hit = find_key(sid, len, r.reward);
          if (hit >= 0) begin
            e.found    = 1'b1;
            e.prob_out = prob_mem[sid][hit];
          end
        end
        default: begin
        end
      endcase
      list_len[sid] = len;
      e.count = len[CNT_W-1:0];
      expected_outcomes.push_back(e);
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Check one accepted result word against the oldest prediction.
    function void check_outcome(logic [OUT_TDATA_W-1:0] word);
      outcome_t e;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, word);
        errors++;
        return;
      end
      e = expected_outcomes.pop_front();
      compare_field("prob_out", e.prob_out, word[31:0]);
      compare_field("found", DATA_W'(e.found), DATA_W'(word[32]));
      compare_field("entry_count", DATA_W'(e.count), DATA_W'(word[37:33]));
      compare_field("status", DATA_W'(e.status), DATA_W'(word[39:38]));
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;

  reward_table_sb    sb = new();
  int                requests_sent = 0;
  int                idle_cycles = 0;
  logic [DATA_W-1:0] reward_pool [16];
  logic [STATE_W-1:0] busy_states [4] = '{6'd0, 6'd21, 6'd42, 6'd63};

  per_key_reward_prob_accumulator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic request_t make_request(logic [REQ_W-1:0] kind, logic [STATE_W-1:0] sid,
                                            logic [DATA_W-1:0] reward, logic [DATA_W-1:0] prob,
                                            logic [SLOT_W-1:0] slot);
    request_t r;
    r.kind   = kind;
    r.sid    = sid;
    r.reward = reward;
    r.prob   = prob;
    r.slot   = slot;
    return r;
  endfunction

  // Offer one request word and hold it until the block takes it.
  task automatic send_request(input request_t r);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {6'd0, r.slot, r.prob, r.reward, r.sid};
    do @(posedge clk); while (!s_axis_tready);
    sb.log_request(r);
    requests_sent++;
  endtask

  // Random request, mostly on a few busy states and a small set of rewards.
  function automatic request_t random_request();
    request_t r;
    int       pick;
    int       len;
    pick = $urandom_range(0, 99);
    if (pick < 50)      r.kind = REQ_INSERT;
    else if (pick < 68) r.kind = REQ_DELETE;
    else if (pick < 95) r.kind = REQ_QUERY;
    else                r.kind = REQ_UNUSED;
    if ($urandom_range(0, 9) < 8) r.sid = busy_states[$urandom_range(0, 3)];
    else                          r.sid = STATE_W'($urandom_range(0, NUM_STATES - 1));
    if ($urandom_range(0, 9) < 7) r.reward = reward_pool[$urandom_range(0, 15)];
    else                          r.reward = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 6)      r.prob = $urandom;
    else if (pick < 8) r.prob = DATA_W'($urandom_range(0, 255));
    else               r.prob = {2'b11, 30'($urandom)};
    len = sb.list_len[r.sid];
    if (len > 0 && $urandom_range(0, 3) != 0) r.slot = SLOT_W'($urandom_range(0, len - 1));
    else                                      r.slot = SLOT_W'($urandom_range(0, 15));
    return r;
  endfunction

  // Directed words: empty lists, extremes, saturation, a full list, shifts.
  task automatic run_directed();
    send_request(make_request(REQ_QUERY,  6'd0, 32'h0000_0000, 32'h0, 4'd0));
    send_request(make_request(REQ_DELETE, 6'd0, 32'h0000_0000, 32'h0, 4'd0));
    send_request(make_request(REQ_UNUSED, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));
    send_request(make_request(REQ_INSERT, 6'd0, 32'h8000_0000, 32'hC000_0000, 4'd0));
    send_request(make_request(REQ_INSERT, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 4'd0));
    send_request(make_request(REQ_QUERY,  6'd0, 32'h8000_0000, 32'h0, 4'd0));
    send_request(make_request(REQ_INSERT, 6'd0, 32'h7FFF_FFFF, 32'h0000_0000, 4'd0));
    send_request(make_request(REQ_INSERT, 6'd0, 32'h7FFF_FFFF, 32'h0000_0001, 4'd0));
    send_request(make_request(REQ_DELETE, 6'd0, 32'h0, 32'h0, 4'd15));
    send_request(make_request(REQ_DELETE, 6'd0, 32'h0, 32'h0, 4'd0));
    send_request(make_request(REQ_QUERY,  6'd0, 32'h7FFF_FFFF, 32'h0, 4'd0));
    // Fill the top state, overflow it, then remove the last and the first entry.
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      send_request(make_request(REQ_INSERT, 6'd63, DATA_W'(i) << 16, $urandom, 4'd0));
    end
    send_request(make_request(REQ_INSERT, 6'd63, 32'hDEAD_0000, 32'hFFFF_FFFF, 4'd0));
    send_request(make_request(REQ_DELETE, 6'd63, 32'h0, 32'h0, 4'd15));
    send_request(make_request(REQ_DELETE, 6'd63, 32'h0, 32'h0, 4'd0));
  endtask

  // Random words in bursts of random length with random gaps between them.
  task automatic run_random(input int total);
    request_t r;
    int       sent;
    int       burst;
    int       gap;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < total; i++) begin
        r = random_request();
        send_request(r);
        if (r.kind != REQ_UNUSED) sent++;
      end
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Main sequence: reset, directed words, random words, drain, verdict.
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    reward_pool[0] = 32'h8000_0000;
    reward_pool[1] = 32'h7FFF_FFFF;
    reward_pool[2] = 32'h0000_0000;
    reward_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 16; i++) reward_pool[i] = $urandom;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(RANDOM_REQUESTS);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: free-running, stalling and choppy stretches, plus one long hold.
  initial begin : receiver
    int  mode;
    int  n;
    bit  long_hold_done;
    long_hold_done = 1'b0;
    m_axis_tready  = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!long_hold_done && requests_sent > 500) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        n    = $urandom_range(1, 60);
        repeat (n) begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 9) < 6);
            default: m_axis_tready <= 1'b0;
          endcase
          @(posedge clk);
          if (mode == 2 && $urandom_range(0, 3) == 0) break;
        end
      end
    end
  end

  // Check every accepted result word.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_outcome(m_axis_tdata);
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
rtl/pkrpa_pkg.sv
rtl/pkrpa_ctrl.sv
rtl/pkrpa_datapath.sv
rtl/per_key_reward_prob_accumulator.sv
tb/per_key_reward_prob_accumulator_tb.sv
